// ----- rtl/fbsc_pkg.sv -----
// Shared types and constants for the frustum box and sphere culling block.
// Holds the plane register layout, the item layout and the verdict codes.
// No dependencies.
package fbsc_pkg;

   localparam int REG_COUNT  = 6;
   localparam int NEAR_INDEX = 1;
   localparam int REG_IDX_W  = 3;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int COORD_W    = 16;
   localparam int RADIUS_W   = 15;
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 8;
   localparam int VERDICT_W  = 2;
   localparam int PROD_W     = 32;
   localparam int SUM_W      = 36;
   localparam int FRAC_SHIFT = 14;

   localparam logic OP_BOX    = 1'b0;
   localparam logic OP_SPHERE = 1'b1;

   localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE  = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_INSIDE   = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_CROSSING = 2'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_CULLED   = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_KEPT     = 2'd1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   // Element 0 is x, in the lowest bits.
   typedef logic [2:0][COORD_W-1:0] vec_type;

   // Normal components in Q1.14, offset in Q8.8; nx in the lowest bits.
   typedef struct packed {
      coord_type d;
      coord_type nz;
      coord_type ny;
      coord_type nx;
   } plane_type;

   // Same layout as the request tdata bus, skip_near in bit 0.
   typedef struct packed {
      logic [RADIUS_W-1:0] radius;
      vec_type             center;
      vec_type             box_max;
      vec_type             box_min;
      logic                skip_near;
   } item_type;

   typedef struct packed {
      logic behind;
      logic crossed;
      logic cull;
   } lane_flags_type;

endpackage

// ----- rtl/fbsc_csr.sv -----
// Plane register file behind the APB-style configuration port.
// Six 64-bit plane registers at 8-byte spacing. Depends on fbsc_pkg.
module fbsc_csr
   import fbsc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [CSR_DATA_W-1:0]       csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output plane_type [REG_COUNT-1:0]   planes
);

   plane_type [REG_COUNT-1:0] planes_ff;
   plane_type [REG_COUNT-1:0] planes_in;
   logic [REG_IDX_W-1:0]      reg_idx;
   logic                      idx_valid;
   logic                      write_en;

   assign reg_idx   = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign idx_valid = (int'(reg_idx) < REG_COUNT);
   assign write_en  = csr_psel & csr_penable & csr_pwrite & idx_valid;

   always_comb begin
      planes_in = planes_ff;
      if (write_en) begin
         planes_in[reg_idx] = plane_type'(csr_pwdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff <= '0;
      end else begin
         planes_ff <= planes_in;
      end
   end

   assign csr_prdata = idx_valid ? CSR_DATA_W'(planes_ff[reg_idx]) : '0;
   assign planes     = planes_ff;

endmodule

// ----- rtl/fbsc_plane_lane.sv -----
// One plane lane: vertex selection, three products per vertex, and the
// plane sums, over three register stages. Depends on fbsc_pkg.
module fbsc_plane_lane
   import fbsc_pkg::*;
(
   input  logic           clock,
   input  logic           enable,
   input  plane_type      plane,
   input  logic           opcode,
   input  item_type       item,
   output lane_flags_type flags
);

   coord_type           normal [3];
   vec_type             opa_in, opb_in, opa_ff, opb_ff;
   logic [RADIUS_W-1:0] bias_in, bias_a_ff, bias_b_ff;
   prod_type            prod_a_in [3];
   prod_type            prod_b_in [3];
   prod_type            prod_a_ff [3];
   prod_type            prod_b_ff [3];
   sum_type             d_term, r_term;
   sum_type             sum_a_in, sum_b_in, sum_a_ff, sum_b_ff;

   assign normal[0] = plane.nx;
   assign normal[1] = plane.ny;
   assign normal[2] = plane.nz;

   // Stage A: vertex A is the positive vertex (the corner furthest along the
   // normal), vertex B the negative one. A sphere puts its center on both
   // and carries the radius as a bias on B.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (opcode == OP_SPHERE) begin
            opa_in[a] = item.center[a];
            opb_in[a] = item.center[a];
         end else if (!normal[a][COORD_W-1]) begin
            opa_in[a] = item.box_max[a];
            opb_in[a] = item.box_min[a];
         end else begin
            opa_in[a] = item.box_min[a];
            opb_in[a] = item.box_max[a];
         end
      end
      bias_in = (opcode == OP_SPHERE) ? item.radius : '0;
   end

   // Stage B: full-precision products at scale 2^-22.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         prod_a_in[a] = normal[a] * $signed(opa_ff[a]);
         prod_b_in[a] = normal[a] * $signed(opb_ff[a]);
      end
   end

   // Stage C: sums of the products, the offset and the radius bias.
   assign d_term   = sum_type'($signed(plane.d)) <<< FRAC_SHIFT;
   assign r_term   = sum_type'({1'b0, bias_b_ff}) <<< FRAC_SHIFT;
   assign sum_a_in = sum_type'(prod_a_ff[0]) + sum_type'(prod_a_ff[1])
                   + sum_type'(prod_a_ff[2]) + d_term;
   assign sum_b_in = sum_type'(prod_b_ff[0]) + sum_type'(prod_b_ff[1])
                   + sum_type'(prod_b_ff[2]) + d_term + r_term;

   always_ff @(posedge clock) begin
      if (enable) begin
         opa_ff    <= opa_in;
         opb_ff    <= opb_in;
         bias_a_ff <= bias_in;
         bias_b_ff <= bias_a_ff;
         for (int a = 0; a < 3; a++) begin
            prod_a_ff[a] <= prod_a_in[a];
            prod_b_ff[a] <= prod_b_in[a];
         end
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
      end
   end

   assign flags.behind  = sum_a_ff[SUM_W-1];
   assign flags.crossed = sum_b_ff[SUM_W-1] | (sum_b_ff == '0);
   assign flags.cull    = sum_b_ff[SUM_W-1];

endmodule

// ----- rtl/frustum_box_sphere_cull.sv -----
// Top level of the frustum culling block: register file, plane lanes and
// verdict stage. Depends on fbsc_pkg, fbsc_csr and fbsc_plane_lane.
//
// Usage: each item on the req_ stream is one bounding volume. req_tuser
// selects a box test (0) or a sphere test (1). A box gives outside (0),
// inside (1) or intersecting (2); a sphere gives culled (0) or kept (1).
// Every item yields exactly one verdict item on the rsp_ stream, in order.
// The six frustum planes are written over the csr_ port, one 64-bit
// register per plane at 8-byte steps; the user must change them only while
// idle, which the block does not enforce. The accepting edge registers
// the selected vertices, then come the multiply, the plane sums, and the
// compare and reduction into the output register. Throughput is one item
// per cycle unless the receiver stalls; every plane has its own lane with
// six 16x16 multipliers, so no unit is shared between items. When the
// receiver stalls, the whole pipeline holds in place and req_tready drops
// while the output register is full and not taken; nothing is lost or
// repeated. Reset empties the pipeline and clears all plane registers to 0.
module frustum_box_sphere_cull
   import fbsc_pkg::*;
#(
   parameter int NUM_PLANES = 6
)
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata from bit 0: skip_near, box_min_x, box_min_y, box_min_z, box_max_x,
   // box_max_y, box_max_z, sphere_center_x, sphere_center_y, sphere_center_z,
   // sphere_radius
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: opcode
   input  logic [0:0]            req_tuser,
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata from bit 0: verdict, then zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Only the first planes in register order take part.
   localparam int LANES = (NUM_PLANES > REG_COUNT) ? REG_COUNT : NUM_PLANES;

   plane_type [REG_COUNT-1:0] planes;
   item_type                  item;
   lane_flags_type            lane_flags [LANES];

   logic                 advance;
   logic                 valid_a_ff, valid_b_ff, valid_c_ff, rsp_valid_ff;
   logic                 opcode_a_ff, opcode_b_ff, opcode_c_ff;
   logic                 skip_a_ff, skip_b_ff, skip_c_ff;
   logic                 any_behind, any_crossed, any_cull;
   logic [VERDICT_W-1:0] verdict_in, verdict_ff;

   fbsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .planes      (planes)
   );

   assign csr_pready = 1'b1;

   // The whole pipeline moves together whenever the output register is free
   // or being emptied this cycle.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign item       = item_type'(req_tdata);

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      fbsc_plane_lane u_lane (
         .clock  (clock),
         .enable (advance),
         .plane  (planes[i]),
         .opcode (req_tuser[0]),
         .item   (item),
         .flags  (lane_flags[i])
      );
   end

   // Verdict: any plane with the box fully behind it culls the box, else any
   // crossed plane makes it intersecting; a sphere is culled by any plane that
   // culls it. The near plane may be skipped for boxes only.
   always_comb begin
      any_behind  = 1'b0;
      any_crossed = 1'b0;
      any_cull    = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         if (!(i == NEAR_INDEX && skip_c_ff && opcode_c_ff == OP_BOX)) begin
            any_behind  = any_behind  | lane_flags[i].behind;
            any_crossed = any_crossed | lane_flags[i].crossed;
            any_cull    = any_cull    | lane_flags[i].cull;
         end
      end
      if (opcode_c_ff == OP_SPHERE) begin
         verdict_in = any_cull ? VERDICT_CULLED : VERDICT_KEPT;
      end else if (any_behind) begin
         verdict_in = VERDICT_OUTSIDE;
      end else if (any_crossed) begin
         verdict_in = VERDICT_CROSSING;
      end else begin
         verdict_in = VERDICT_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
         valid_c_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff   <= req_tvalid;
         valid_b_ff   <= valid_a_ff;
         valid_c_ff   <= valid_b_ff;
         rsp_valid_ff <= valid_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         opcode_a_ff <= req_tuser[0];
         opcode_b_ff <= opcode_a_ff;
         opcode_c_ff <= opcode_b_ff;
         skip_a_ff   <= item.skip_near;
         skip_b_ff   <= skip_a_ff;
         skip_c_ff   <= skip_b_ff;
         verdict_ff  <= verdict_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-VERDICT_W){1'b0}}, verdict_ff};

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for frustum_box_sphere_cull: box and sphere items
// against several plane sets, with a scoreboard class that predicts verdicts.
// Depends on fbsc_pkg and the frustum_box_sphere_cull RTL.
module testbench;
   import fbsc_pkg::*;

   localparam int NUM_PLANES    = 6;
   localparam int PLANES_TESTED = (NUM_PLANES < REG_COUNT) ? NUM_PLANES : REG_COUNT;
   // Margin for the pipeline to empty after the last verdict has come back.
   localparam int DRAIN_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 250000;
   localparam int MAX_GAP       = 13;
   // The receiver holds off once, for a long stretch, after this many verdicts.
   localparam int LONG_HOLD_AT     = 400;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int ONE = 256;     // 1.0 in Q8.8
   localparam int UNIT = 16384;  // 1.0 in Q1.14
   localparam int DIAG = 11585;  // cos(45 degrees) in Q1.14

   typedef enum int {
      PLANE_FAR    = 0,
      PLANE_NEAR   = 1,
      PLANE_LEFT   = 2,
      PLANE_RIGHT  = 3,
      PLANE_BOTTOM = 4,
      PLANE_TOP    = 5
   } plane_index_type;

   // One request item: the tuser opcode beside the packed tdata layout.
   typedef struct packed {
      logic     opcode;
      item_type body;
   } volume_type;

   // Scoreboard: keeps its own copy of the planes, predicts one verdict per
   // accepted item and checks the verdicts in order.
   class cull_scoreboard;
      plane_type            planes [REG_COUNT];
      logic [VERDICT_W-1:0] expected_verdicts [$];
      int                   mismatch_count;

      function new();
         foreach (planes[i]) planes[i] = '0;
         mismatch_count = 0;
      endfunction

      function void set_plane(int idx, plane_type p);
         planes[idx] = p;
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatch_count++;
      endtask

      // n.p + d at scale 2^-22, exact.
      function sum_type plane_value(plane_type p, coord_type x, coord_type y, coord_type z);
         sum_type acc;
         acc = sum_type'($signed(p.d)) <<< FRAC_SHIFT;
         acc += sum_type'($signed(p.nx)) * sum_type'(x);
         acc += sum_type'($signed(p.ny)) * sum_type'(y);
         acc += sum_type'($signed(p.nz)) * sum_type'(z);
         return acc;
      endfunction

      function logic [VERDICT_W-1:0] box_verdict(item_type b);
         coord_type            lo [3];
         coord_type            hi [3];
         coord_type            pv [3];
         coord_type            nv [3];
         coord_type            n  [3];
         logic [VERDICT_W-1:0] verdict;
         for (int a = 0; a < 3; a++) begin
            lo[a] = b.box_min[a];
            hi[a] = b.box_max[a];
         end
         verdict = VERDICT_OUTSIDE;
         for (int i = 0; i < PLANES_TESTED; i++) begin
            if (i == NEAR_INDEX && b.skip_near) continue;
            n[0] = planes[i].nx;
            n[1] = planes[i].ny;
            n[2] = planes[i].nz;
            // The positive vertex takes the max where the normal is not
            // negative; min and max are used as given, even when inverted.
            for (int a = 0; a < 3; a++) begin
               pv[a] = (n[a] >= 0) ? hi[a] : lo[a];
               nv[a] = (n[a] >= 0) ? lo[a] : hi[a];
            end
            if (plane_value(planes[i], pv[0], pv[1], pv[2]) < 0) return VERDICT_OUTSIDE;
            if (plane_value(planes[i], nv[0], nv[1], nv[2]) > 0) begin
               if (verdict != VERDICT_CROSSING) verdict = VERDICT_INSIDE;
            end else begin
               verdict = VERDICT_CROSSING;
            end
         end
         return verdict;
      endfunction

      function logic [VERDICT_W-1:0] sphere_verdict(item_type b);
         sum_type r;
         r = sum_type'({1'b0, b.radius}) <<< FRAC_SHIFT;
         for (int i = 0; i < PLANES_TESTED; i++) begin
            if (-plane_value(planes[i], b.center[0], b.center[1], b.center[2]) > r)
               return VERDICT_CULLED;
         end
         return VERDICT_KEPT;
      endfunction

      function void note(volume_type v);
         if (v.opcode == OP_BOX) expected_verdicts.push_back(box_verdict(v.body));
         else expected_verdicts.push_back(sphere_verdict(v.body));
      endfunction

      task check(logic [RSP_DATA_W-1:0] data);
         logic [VERDICT_W-1:0] want;
         if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict %0d with no item outstanding", data));
         end else begin
            want = expected_verdicts.pop_front();
            if (data[VERDICT_W-1:0] !== want)
               report_mismatch($sformatf("verdict %0d, expected %0d",
                                         data[VERDICT_W-1:0], want));
         end
      endtask
   endclass

   // Every input of the block starts at a known value; reset is held high.
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [0:0]            req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   cull_scoreboard verdicts;
   bit             send_burst = 1'b0;
   bit             recv_burst = 1'b0;
   int             cycle_count = 0;

   frustum_box_sphere_cull #(.NUM_PLANES(NUM_PLANES)) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #5 clock = ~clock;

   // A run that hangs ends here with the failure message.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("frustum_box_sphere_cull verification failed");
         $finish;
      end
   end

   // Every verdict handed over is checked against the oldest prediction.
   // Sampling right after the edge sees the values the block saw.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) verdicts.check(rsp_tdata);
   end

   // Receiver: a random stall before each verdict, with stretches of none,
   // and one long hold-off so that the pipeline fills and req_tready drops.
   initial begin
      int stall;
      int taken;
      taken = 0;
      wait (!reset);
      forever begin
         if (taken == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
         else stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
      end
   end

   function automatic plane_type make_plane(int nx, int ny, int nz, int d);
      plane_type p;
      p.nx = coord_type'(nx);
      p.ny = coord_type'(ny);
      p.nz = coord_type'(nz);
      p.d  = coord_type'(d);
      return p;
   endfunction

   function automatic item_type random_body();
      return item_type'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
   endfunction

   // Sphere fields stay random in box items, and box fields in sphere items.
   function automatic volume_type box_item(bit skip, int lx, int ly, int lz,
                                           int hx, int hy, int hz);
      volume_type v;
      v.opcode            = OP_BOX;
      v.body              = random_body();
      v.body.skip_near    = skip;
      v.body.box_min[0]   = COORD_W'(lx);
      v.body.box_min[1]   = COORD_W'(ly);
      v.body.box_min[2]   = COORD_W'(lz);
      v.body.box_max[0]   = COORD_W'(hx);
      v.body.box_max[1]   = COORD_W'(hy);
      v.body.box_max[2]   = COORD_W'(hz);
      return v;
   endfunction

   function automatic volume_type sphere_item(bit skip, int cx, int cy, int cz, int r);
      volume_type v;
      v.opcode         = OP_SPHERE;
      v.body           = random_body();
      v.body.skip_near = skip;
      v.body.center[0] = COORD_W'(cx);
      v.body.center[1] = COORD_W'(cy);
      v.body.center[2] = COORD_W'(cz);
      v.body.radius    = RADIUS_W'(r);
      return v;
   endfunction

   // Most items are well-formed volumes around the origin with random sizes;
   // the rest are raw noise over every bit. Some boxes come inverted.
   function automatic volume_type random_volume(int spread);
      volume_type v;
      int         c;
      int         h;
      v.opcode = 1'($urandom_range(0, 1));
      v.body   = random_body();
      if ($urandom_range(0, 99) < 15) return v;
      for (int a = 0; a < 3; a++) begin
         c = int'($urandom_range(0, 2 * spread)) - spread;
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40 * ONE)
                                         : $urandom_range(0, 6 * ONE);
         if (v.opcode == OP_BOX) begin
            if ($urandom_range(0, 15) == 0) begin
               v.body.box_min[a] = COORD_W'(c + h);
               v.body.box_max[a] = COORD_W'(c - h);
            end else begin
               v.body.box_min[a] = COORD_W'(c - h);
               v.body.box_max[a] = COORD_W'(c + h);
            end
         end else begin
            v.body.center[a] = COORD_W'(c);
         end
      end
      if (v.opcode == OP_SPHERE && $urandom_range(0, 9) != 0)
         v.body.radius = RADIUS_W'($urandom_range(0, 8 * ONE));
      return v;
   endfunction

   // Offers one item after a random gap and returns at the accepting edge,
   // where the prediction is made. req_tvalid is left high for the caller.
   task send_volume(volume_type v);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v.body;
      req_tuser  <= v.opcode;
      do @(posedge clock); while (!req_tready);
      verdicts.note(v);
      if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
   endtask

   task send_random(int count, int spread);
      repeat (count) send_volume(random_volume(spread));
   endtask

   // Stops offering items and waits until every verdict has come back and the
   // pipeline has had time to empty.
   task drain();
      req_tvalid <= 1'b0;
      while (verdicts.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: setup phase, then access until pready. The select is
   // left high so that transfers can follow back to back.
   task csr_transfer(bit write, int idx, logic [CSR_DATA_W-1:0] wdata,
                     output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_W'(idx * 8);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   // Writes all six planes, reading each one back. Only called while idle.
   task load_planes(plane_type frame [REG_COUNT]);
      logic [CSR_DATA_W-1:0] readback;
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_transfer(1'b1, i, frame[i], readback);
         verdicts.set_plane(i, frame[i]);
         csr_transfer(1'b0, i, '0, readback);
         if (readback !== CSR_DATA_W'(frame[i]))
            verdicts.report_mismatch($sformatf("plane register %0d reads %h, wrote %h",
                                               i, readback, frame[i]));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      plane_type frame [REG_COUNT];
      verdicts = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All planes are zero after reset: every plane value is exactly zero,
      // so boxes come out intersecting and spheres are kept.
      send_volume(box_item(1'b0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
      send_volume(box_item(1'b1, 32767, 32767, 32767, 32767, 32767, 32767));
      send_volume(sphere_item(1'b0, -32768, 32767, 0, 0));
      drain();

      // A symmetric frustum looking down +z: 1 < z < 20 and 45-degree sides.
      frame[PLANE_FAR]    = make_plane(0, 0, -UNIT, 20 * ONE);
      frame[PLANE_NEAR]   = make_plane(0, 0, UNIT, -ONE);
      frame[PLANE_LEFT]   = make_plane(DIAG, 0, DIAG, 0);
      frame[PLANE_RIGHT]  = make_plane(-DIAG, 0, DIAG, 0);
      frame[PLANE_BOTTOM] = make_plane(0, DIAG, DIAG, 0);
      frame[PLANE_TOP]    = make_plane(0, -DIAG, DIAG, 0);
      load_planes(frame);

      // Boxes: fully inside, fully behind the near plane, and a small box
      // just short of the near plane that the near skip lets through.
      send_volume(box_item(1'b0, -ONE, -ONE, 5 * ONE, ONE, ONE, 6 * ONE));
      send_volume(box_item(1'b0, -ONE, -ONE, -3 * ONE, ONE, ONE, -2 * ONE));
      send_volume(box_item(1'b0, -ONE / 4, -ONE / 4, ONE / 2, ONE / 4, ONE / 4, 3 * ONE / 4));
      send_volume(box_item(1'b1, -ONE / 4, -ONE / 4, ONE / 2, ONE / 4, ONE / 4, 3 * ONE / 4));
      // Straddling the far plane.
      send_volume(box_item(1'b0, -ONE, -ONE, 18 * ONE, ONE, ONE, 22 * ONE));
      // A corner exactly on the near plane, from either side: the plane value
      // is zero there, which counts as crossed.
      send_volume(box_item(1'b0, -ONE / 2, -ONE / 2, ONE, ONE / 2, ONE / 2, 2 * ONE));
      send_volume(box_item(1'b0, -ONE / 4, -ONE / 4, ONE / 2, ONE / 4, ONE / 4, ONE));
      // Min above max on every axis; the corners are not swapped.
      send_volume(box_item(1'b0, ONE, ONE, 6 * ONE, -ONE, -ONE, 5 * ONE));
      // Coordinate extremes.
      send_volume(box_item(1'b0, -32768, -32768, -32768, 32767, 32767, 32767));
      send_volume(box_item(1'b0, 32767, 32767, 32767, 32767, 32767, 32767));
      send_volume(box_item(1'b1, -32768, -32768, -32768, -32768, -32768, -32768));
      // Spheres: inside, behind the near plane (also with the near skip set,
      // which spheres ignore), and touching the near plane exactly versus
      // reaching one step short of it.
      send_volume(sphere_item(1'b0, 0, 0, 10 * ONE, ONE));
      send_volume(sphere_item(1'b0, 0, 0, -5 * ONE, ONE));
      send_volume(sphere_item(1'b1, 0, 0, -5 * ONE, ONE));
      send_volume(sphere_item(1'b0, 0, 0, 0, ONE));
      send_volume(sphere_item(1'b0, 0, 0, 0, ONE - 1));
      send_volume(sphere_item(1'b0, 32767, 32767, 32767, 32767));
      send_volume(sphere_item(1'b1, -32768, -32768, -32768, 0));
      send_random(280, 30 * ONE);
      drain();

      // A narrower, shifted frustum with 30-degree sides and offsets.
      frame[PLANE_FAR]    = make_plane(0, 0, -UNIT, 12 * ONE);
      frame[PLANE_NEAR]   = make_plane(0, 0, UNIT, -3 * ONE);
      frame[PLANE_LEFT]   = make_plane(14189, 0, 8192, 2 * ONE);
      frame[PLANE_RIGHT]  = make_plane(-14189, 0, 8192, -ONE);
      frame[PLANE_BOTTOM] = make_plane(0, 14189, 8192, ONE);
      frame[PLANE_TOP]    = make_plane(0, -14189, 8192, 0);
      load_planes(frame);
      send_random(280, 30 * ONE);
      drain();

      // Register extremes: every field at its maximum, then at its minimum,
      // then the two alternating between planes.
      foreach (frame[i]) frame[i] = make_plane(32767, 32767, 32767, 32767);
      load_planes(frame);
      send_random(120, 20000);
      drain();
      foreach (frame[i]) frame[i] = make_plane(-32768, -32768, -32768, -32768);
      load_planes(frame);
      send_random(120, 20000);
      drain();
      foreach (frame[i]) begin
         if (i % 2 == 0) frame[i] = make_plane(32767, -32768, 32767, -32768);
         else frame[i] = make_plane(-32768, 32767, -32768, 32767);
      end
      load_planes(frame);
      send_random(120, 20000);
      drain();

      // Random plane sets: mostly normals of moderate length with modest
      // offsets, now and then a fully random register.
      repeat (4) begin
         foreach (frame[i]) begin
            if ($urandom_range(0, 3) == 0)
               frame[i] = plane_type'({$urandom(), $urandom()});
            else
               frame[i] = make_plane(int'($urandom_range(0, 2 * UNIT)) - UNIT,
                                     int'($urandom_range(0, 2 * UNIT)) - UNIT,
                                     int'($urandom_range(0, 2 * UNIT)) - UNIT,
                                     int'($urandom_range(0, 32 * ONE)) - 16 * ONE);
         end
         load_planes(frame);
         send_random(180, 40 * ONE);
         drain();
      end

      if (verdicts.mismatch_count == 0) begin
         $display("frustum_box_sphere_cull verification clean");
      end else begin
         $display("frustum_box_sphere_cull verification failed");
      end
      $finish;
   end

endmodule
